>>> src/vbnt_pkg.sv
// ----------------------------------------------------------------------------
// vbnt_pkg
// Shared types, constants and the address decode for the video bus
// nametable and palette decoder.
// ----------------------------------------------------------------------------
package vbnt_pkg;

    localparam int NAMETABLE_BYTES = 2048;
    localparam int PALETTE_BYTES   = 32;
    localparam int NT_AW           = $clog2(NAMETABLE_BYTES);
    localparam int PAL_AW          = $clog2(PALETTE_BYTES);

    localparam logic [15:0] PATTERN_TOP   = 16'h1FFF;
    localparam logic [15:0] NAMETABLE_TOP = 16'h3EFF;
    localparam logic [15:0] PALETTE_TOP   = 16'h3FFF;
    localparam logic [15:0] FOLD_START    = 16'h3000;
    localparam logic [15:0] FOLD_STEP     = 16'h1000;

    typedef enum logic [2:0] {
        MIR_HORIZ    = 3'd0,
        MIR_VERT     = 3'd1,
        MIR_ONE_LOW  = 3'd2,
        MIR_ONE_HIGH = 3'd3,
        MIR_FOUR     = 3'd4
    } mirror_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_NT   = 2'd1,
        KIND_PAL  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               wr;
        logic [NT_AW-1:0]   nt_idx;
        logic [PAL_AW-1:0]  pal_idx;
        logic               fwd;
        logic [13:0]        maddr;
        logic               mwr;
        logic [7:0]         mdata;
    } dec_t;

    function automatic dec_t decode(logic wr, logic [15:0] addr, logic [7:0] data,
                                    logic [2:0] mode);
        dec_t        d;
        logic [15:0] norm;
        logic [1:0]  q;
        logic        base;
        logic [4:0]  p;
        d         = '0;
        d.kind    = KIND_NONE;
        d.wr      = wr;
        norm      = (addr >= FOLD_START) ? (addr - FOLD_STEP) : addr;
        q         = norm[11:10];
        p         = addr[4:0];
        if (p[4] && (p[1:0] == 2'b00))
        begin
            p[4] = 1'b0;
        end
        unique case (mode)
            MIR_HORIZ:    base = q[1];
            MIR_VERT:     base = q[0];
            MIR_ONE_HIGH: base = 1'b1;
            default:      base = 1'b0;
        endcase
        if (addr <= PATTERN_TOP)
        begin
            d.fwd   = 1'b1;
            d.maddr = addr[13:0];
        end
        else if (addr <= NAMETABLE_TOP)
        begin
            if (mode == MIR_FOUR)
            begin
                d.fwd   = 1'b1;
                d.maddr = norm[13:0];
            end
            else
            begin
                d.kind   = KIND_NT;
                d.nt_idx = {base, addr[9:0]};
            end
        end
        else if (addr <= PALETTE_TOP)
        begin
            d.kind    = KIND_PAL;
            d.pal_idx = p;
        end
        d.mwr   = d.fwd & wr;
        d.mdata = (d.fwd && wr) ? data : 8'h00;
        return d;
    endfunction

endpackage

>>> src/video_bus_nametable_palette_decode_top.sv
// ----------------------------------------------------------------------------
// video_bus_nametable_palette_decode_top
// Video bus decoder: forwards pattern and four-screen accesses to the mapper,
// serves nametable and palette accesses from internal synchronous RAM.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled; each result
// passes through the synchronous RAM read stage and then the output
// register, and a write is visible to a read in the next cycle.
// After reset the block runs a clearing pass over the nametable RAM (the
// palette RAM is cleared alongside); in_ready stays low until it ends,
// while mirror mode writes are taken throughout.
module video_bus_nametable_palette_decode_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        to_mapper,
    output logic [13:0] mapper_address,
    output logic        mapper_is_write,
    output logic [7:0]  mapper_data
);

    logic [7:0] nt_mem  [vbnt_pkg::NAMETABLE_BYTES];
    logic [7:0] pal_mem [vbnt_pkg::PALETTE_BYTES];
    logic [7:0] nt_q;
    logic [7:0] pal_q;

    logic [2:0]                  mirror_reg;
    logic [vbnt_pkg::NT_AW-1:0]  clr_cnt_reg;
    logic                        clr_done_reg;
    logic                        s1_valid_reg;
    vbnt_pkg::dec_t              s1_req_reg;
    logic                        out_valid_reg;
    logic [7:0]                  rd_reg;
    logic                        fwd_reg;
    logic [13:0]                 maddr_reg;
    logic                        mwr_reg;
    logic [7:0]                  mdata_reg;

    vbnt_pkg::dec_t dec;
    logic           accept;
    logic           s1_adv;
    logic [7:0]     rd_next;
    logic           nt_we;
    logic           nt_re;
    logic           pal_we;
    logic           pal_re;

    assign dec      = vbnt_pkg::decode(action, address, write_data, mirror_reg);
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = clr_done_reg && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;
    assign nt_we    = accept && (dec.kind == vbnt_pkg::KIND_NT) && dec.wr;
    assign nt_re    = accept && (dec.kind == vbnt_pkg::KIND_NT) && !dec.wr;
    assign pal_we   = accept && (dec.kind == vbnt_pkg::KIND_PAL) && dec.wr;
    assign pal_re   = accept && (dec.kind == vbnt_pkg::KIND_PAL) && !dec.wr;

    always_comb
    begin
        rd_next = 8'h00;
        if (!s1_req_reg.wr)
        begin
            unique case (s1_req_reg.kind)
                vbnt_pkg::KIND_NT:  rd_next = nt_q;
                vbnt_pkg::KIND_PAL: rd_next = pal_q;
                default:            rd_next = 8'h00;
            endcase
        end
    end

    // clear, then serve requests
    always_ff @(posedge clk)
    begin
        if (!clr_done_reg)
        begin
            nt_mem[clr_cnt_reg] <= 8'h00;
        end
        else if (nt_we)
        begin
            nt_mem[dec.nt_idx] <= write_data;
        end
        if (nt_re)
        begin
            nt_q <= nt_mem[dec.nt_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr_done_reg)
        begin
            pal_mem[clr_cnt_reg[vbnt_pkg::PAL_AW-1:0]] <= 8'h00;
        end
        else if (pal_we)
        begin
            pal_mem[dec.pal_idx] <= write_data;
        end
        if (pal_re)
        begin
            pal_q <= pal_mem[dec.pal_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg    <= vbnt_pkg::MIR_HORIZ;
            clr_cnt_reg   <= '0;
            clr_done_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mirror_reg <= cfg_data;
            end
            if (!clr_done_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == vbnt_pkg::NT_AW'(vbnt_pkg::NAMETABLE_BYTES - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold payload until advanced
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg <= dec;
        end
        if (s1_adv)
        begin
            rd_reg    <= rd_next;
            fwd_reg   <= s1_req_reg.fwd;
            maddr_reg <= s1_req_reg.maddr;
            mwr_reg   <= s1_req_reg.mwr;
            mdata_reg <= s1_req_reg.mdata;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = rd_reg;
    assign to_mapper       = fwd_reg;
    assign mapper_address  = maddr_reg;
    assign mapper_is_write = mwr_reg;
    assign mapper_data     = mdata_reg;

    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done_reg |-> !in_ready)
        else $error("request taken during clearing pass");

    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_req_reg)))
        else $error("stalled stage lost its request");

    a_local_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !to_mapper) |->
            (mapper_address == 14'd0 && !mapper_is_write && mapper_data == 8'h00))
        else $error("mapper fields set on local access");

    a_forward_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && to_mapper) |-> (read_data == 8'h00))
        else $error("read data on forwarded access");

endmodule
